// ----- hw/rtl/pfgr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfgr_pkg: shared definitions of the planar font glyph renderer
// Field widths, default sizes, operation codes and the character to glyph map.
// ----------------------------------------------------------------------------
package pfgr_pkg;

  localparam int FONT_DEPTH_DEF = 2048;
  localparam int GLYPH_ROWS_DEF = 12;

  localparam int ADDR_W  = 11;
  localparam int BYTE_W  = 8;
  localparam int CODE_W  = 8;
  localparam int PIX_W   = 32;
  localparam int ROW_W   = 4;
  localparam int GLYPH_W = 6;
  localparam int PLANES  = 4;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_RENDER = 1'b1
  } op_t;

  // Glyph numbers of the punctuation marks and the first letter.
  localparam logic [GLYPH_W-1:0] GLYPH_EXCL   = 6'd10;
  localparam logic [GLYPH_W-1:0] GLYPH_QUEST  = 6'd11;
  localparam logic [GLYPH_W-1:0] GLYPH_DOT    = 6'd12;
  localparam logic [GLYPH_W-1:0] GLYPH_DOLLAR = 6'd13;
  localparam logic [GLYPH_W-1:0] GLYPH_UNDER  = 6'd14;
  localparam logic [GLYPH_W-1:0] GLYPH_ALPHA  = 6'd15;

  // Every pixel at colour 1, used for codes that have no glyph.
  localparam logic [PIX_W-1:0] PIX_UNMAPPED = 32'h1111_1111;

  typedef struct packed {
    logic               hit;
    logic [GLYPH_W-1:0] idx;
  } glyph_t;

  function automatic glyph_t glyph_of(input logic [CODE_W-1:0] c);
    glyph_t g;
    g.hit = 1'b1;
    g.idx = '0;
    if (c >= 8'h61 && c <= 8'h7A) begin
      g.idx = GLYPH_W'(c - 8'h61) + GLYPH_ALPHA;
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      g.idx = GLYPH_W'(c - 8'h41) + GLYPH_ALPHA;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      g.idx = GLYPH_W'(c - 8'h30);
    end else if (c == 8'h21) begin
      g.idx = GLYPH_EXCL;
    end else if (c == 8'h3F) begin
      g.idx = GLYPH_QUEST;
    end else if (c == 8'h2E) begin
      g.idx = GLYPH_DOT;
    end else if (c == 8'h24) begin
      g.idx = GLYPH_DOLLAR;
    end else if (c == 8'h5F) begin
      g.idx = GLYPH_UNDER;
    end else begin
      g.hit = 1'b0;
    end
    return g;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/pfgr_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfgr_if: stream channels of the planar font glyph renderer
// Command channel (load or render) and pixel row channel, valid/ready each.
// ----------------------------------------------------------------------------
interface pfgr_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [pfgr_pkg::ADDR_W-1:0] font_addr;
  logic [pfgr_pkg::BYTE_W-1:0] font_byte;
  logic [pfgr_pkg::CODE_W-1:0] char_code;

  modport source (output valid, op, font_addr, font_byte, char_code, input ready);
  modport sink   (input valid, op, font_addr, font_byte, char_code, output ready);
endinterface

interface pfgr_out_if;
  logic                       valid;
  logic                       ready;
  logic [pfgr_pkg::PIX_W-1:0] row_pixels;
  logic [pfgr_pkg::ROW_W-1:0] row_index;
  logic                       last_row;

  modport source (output valid, row_pixels, row_index, last_row, input ready);
  modport sink   (input valid, row_pixels, row_index, last_row, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/pfgr_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfgr_ram: generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module pfgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/planar_font_glyph_renderer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// planar_font_glyph_renderer: character generator over a planar font store
// Loads font bytes and renders characters as rows of eight 4-bit pixels.
// ----------------------------------------------------------------------------
// A load transfer writes one byte into the font store; it
// gives no output. A render transfer maps the character code to a glyph and
// emits GLYPH_ROWS row transfers, top row first. Each glyph is stored as four
// bit planes of GLYPH_ROWS bytes, plane k at glyph*4*GLYPH_ROWS + k*GLYPH_ROWS;
// pixel bit k comes from plane k, the most significant plane bit being the
// leftmost pixel. Codes without a glyph give every pixel colour 1. The font
// store has a single port, so each row of a mapped character takes four
// plane reads, one after another, before it is assembled and offered on
// the output; an unmapped character reads nothing. The command channel is
// ready only between characters. The font store is not cleared; only
// written bytes may be rendered.
// ----------------------------------------------------------------------------
module planar_font_glyph_renderer #(
  parameter int FONT_DEPTH = pfgr_pkg::FONT_DEPTH_DEF,
  parameter int GLYPH_ROWS = pfgr_pkg::GLYPH_ROWS_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  pfgr_in_if.sink    cmd,
  pfgr_out_if.source pix
);

  localparam int AW = $clog2(FONT_DEPTH);
  // Plane addresses stay below twice the store depth, so one subtract wraps.
  localparam int SW = $clog2(2 * FONT_DEPTH);
  localparam int GLYPH_BYTES = pfgr_pkg::PLANES * GLYPH_ROWS;
  localparam int PW = $clog2(pfgr_pkg::PLANES);
  localparam logic [PW-1:0] LAST_PLANE = PW'(pfgr_pkg::PLANES - 1);
  localparam logic [pfgr_pkg::ROW_W-1:0] LAST_ROW = pfgr_pkg::ROW_W'(GLYPH_ROWS - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_LAST = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state;

  logic                          mapped;
  logic [SW-1:0]                 row_base;
  logic [SW-1:0]                 plane_addr;
  logic [PW-1:0]                 plane;
  logic [pfgr_pkg::BYTE_W-1:0]   plane_q [pfgr_pkg::PLANES-1];
  logic [pfgr_pkg::PIX_W-1:0]    out_pixels;
  logic [pfgr_pkg::ROW_W-1:0]    out_row;

  logic                          cmd_xfer;
  logic                          pix_xfer;
  pfgr_pkg::glyph_t              glyph;
  logic                          ram_we;
  logic [AW-1:0]                 ram_addr;
  logic [AW-1:0]                 rd_idx;
  logic [SW-1:0]                 wrapped;
  logic [pfgr_pkg::BYTE_W-1:0]   ram_rdata;
  logic [pfgr_pkg::PIX_W-1:0]    pix_asm;

  assign cmd.ready = (state == S_IDLE);
  assign cmd_xfer  = cmd.valid && cmd.ready;
  assign pix_xfer  = pix.valid && pix.ready;
  assign glyph     = pfgr_pkg::glyph_of(cmd.char_code);

  // The shared address unit: the plane address wraps past the store end.
  assign wrapped = (plane_addr >= SW'(FONT_DEPTH)) ? plane_addr - SW'(FONT_DEPTH)
                                                   : plane_addr;
  assign rd_idx  = wrapped[AW-1:0];

  // Loads use the port only while idle, plane reads only while reading.
  assign ram_we   = cmd_xfer && (cmd.op == pfgr_pkg::OP_LOAD);
  assign ram_addr = ram_we ? AW'(cmd.font_addr) : rd_idx;

  pfgr_ram #(
    .WIDTH (pfgr_pkg::BYTE_W),
    .DEPTH (FONT_DEPTH)
  ) u_font (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (cmd.font_byte),
    .rdata (ram_rdata)
  );

  // Pixel assembly: plane three arrives straight from the store.
  always_comb begin
    for (int px = 0; px < 8; px++) begin
      pix_asm[4*(7-px) +: 4] = {ram_rdata[7-px], plane_q[2][7-px],
                                plane_q[1][7-px], plane_q[0][7-px]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_xfer && cmd.op == pfgr_pkg::OP_RENDER) begin
            state <= glyph.hit ? S_READ : S_OUT;
          end
        end
        S_READ: begin
          if (plane == LAST_PLANE) begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (pix_xfer) begin
            if (out_row == LAST_ROW) begin
              state <= S_IDLE;
            end else begin
              state <= mapped ? S_READ : S_OUT;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        mapped     <= glyph.hit;
        row_base   <= SW'(glyph.idx * GLYPH_BYTES);
        plane_addr <= SW'(glyph.idx * GLYPH_BYTES);
        plane      <= '0;
        out_row    <= '0;
        out_pixels <= pfgr_pkg::PIX_UNMAPPED;
      end
      S_READ: begin
        // The byte read in the previous cycle lands one plane behind.
        if (plane != '0) begin
          plane_q[PW'(plane - 1'b1)] <= ram_rdata;
        end
        if (plane != LAST_PLANE) begin
          plane_addr <= plane_addr + SW'(GLYPH_ROWS);
          plane      <= plane + 1'b1;
        end
      end
      S_LAST: begin
        out_pixels <= pix_asm;
      end
      S_OUT: begin
        if (pix_xfer && out_row != LAST_ROW) begin
          out_row    <= out_row + 1'b1;
          row_base   <= row_base + 1'b1;
          plane_addr <= row_base + 1'b1;
          plane      <= '0;
        end
      end
      default: begin
        out_row <= out_row;
      end
    endcase
  end

  assign pix.valid      = (state == S_OUT);
  assign pix.row_pixels = out_pixels;
  assign pix.row_index  = out_row;
  assign pix.last_row   = (out_row == LAST_ROW);

  // A finished glyph always returns the block to idle.
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (pix_xfer && pix.last_row) |=> (state == S_IDLE))
    else $error("block did not return to idle after the last row");

  // Rows follow one another without a gap or a repeat.
  a_row_step: assert property (@(posedge clk) disable iff (rst)
    (pix_xfer && !pix.last_row) |=> (out_row == $past(out_row) + 1'b1))
    else $error("row index did not advance by one");

  // A plane read never leaves the store, and the first row starts at zero.
  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (wrapped < SW'(FONT_DEPTH)))
    else $error("plane address beyond font store");

  a_first_row: assert property (@(posedge clk) disable iff (rst)
    (cmd_xfer && cmd.op == pfgr_pkg::OP_RENDER) |=> (out_row == '0))
    else $error("render did not start at the top row");

endmodule
`default_nettype wire

// ----- test/planar_font_glyph_renderer_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfgr_render_checker: scoreboard for the planar font glyph renderer
// Mirrors the font store from observed load transfers, predicts the pixel
// rows of every accepted render transfer and compares each row transfer on
// the output channel against the oldest prediction.
// ----------------------------------------------------------------------------

package pfgr_check_pkg;
  import pfgr_pkg::*;

  // Character codes at the edges of the glyph map.
  localparam logic [CODE_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CODE_W-1:0] CH_UPPER_A = 8'h41;
  localparam logic [CODE_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CODE_W-1:0] CH_EXCL    = 8'h21;
  localparam logic [CODE_W-1:0] CH_QUEST   = 8'h3F;
  localparam logic [CODE_W-1:0] CH_DOT     = 8'h2E;
  localparam logic [CODE_W-1:0] CH_DOLLAR  = 8'h24;
  localparam logic [CODE_W-1:0] CH_UNDER   = 8'h5F;

  localparam int GLYPH_COUNT = int'(GLYPH_ALPHA) + 26;

  // Glyph number of a character code, or -1 when the code has no glyph.
  function automatic int glyph_number(input logic [CODE_W-1:0] c);
    int g;
    g = -1;
    if (c >= CH_LOWER_A && c < CH_LOWER_A + 8'd26) begin
      g = int'(c - CH_LOWER_A) + int'(GLYPH_ALPHA);
    end else if (c >= CH_UPPER_A && c < CH_UPPER_A + 8'd26) begin
      g = int'(c - CH_UPPER_A) + int'(GLYPH_ALPHA);
    end else if (c >= CH_ZERO && c < CH_ZERO + 8'd10) begin
      g = int'(c - CH_ZERO);
    end else begin
      case (c)
        CH_EXCL:   g = int'(GLYPH_EXCL);
        CH_QUEST:  g = int'(GLYPH_QUEST);
        CH_DOT:    g = int'(GLYPH_DOT);
        CH_DOLLAR: g = int'(GLYPH_DOLLAR);
        CH_UNDER:  g = int'(GLYPH_UNDER);
        default:   g = -1;
      endcase
    end
    return g;
  endfunction

endpackage

module pfgr_render_checker #(
  parameter int FONT_DEPTH = pfgr_pkg::FONT_DEPTH_DEF,
  parameter int GLYPH_ROWS = pfgr_pkg::GLYPH_ROWS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  pfgr_in_if        cmd,
  pfgr_out_if       pix,
  output int        fail_count,
  output int        rows_pending,
  output int        rows_checked
);
  import pfgr_pkg::*;
  import pfgr_check_pkg::*;

  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [PIX_W-1:0] pixels;
    logic [ROW_W-1:0] row;
    logic             last;
  } pixel_row_t;

  logic [BYTE_W-1:0] font_mirror [FONT_DEPTH];
  pixel_row_t        rows_due [$];
  int                mismatches = 0;
  int                backlog = 0;
  int                rows_seen = 0;

  assign fail_count   = mismatches;
  assign rows_pending = backlog;
  assign rows_checked = rows_seen;

  // Prints one line per failure (up to a cap) and counts every one.
  task automatic report(input string what);
    if (mismatches < MAX_REPORTS) begin
      $display("[%0t] render check: %s", $time, what);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin : predict_and_compare
    pixel_row_t        want;
    int                g;
    int                base;
    logic [BYTE_W-1:0] plane [PLANES];
    if (rst) begin
      rows_due.delete();
    end else begin
      if (cmd.valid && cmd.ready) begin
        if (cmd.op == OP_LOAD) begin
          font_mirror[int'(cmd.font_addr) % FONT_DEPTH] = cmd.font_byte;
        end else begin
          g = glyph_number(cmd.char_code);
          for (int row = 0; row < GLYPH_ROWS; row++) begin
            want.pixels = PIX_UNMAPPED;
            if (g >= 0) begin
              base = g * PLANES * GLYPH_ROWS + row;
              for (int k = 0; k < PLANES; k++) begin
                plane[k] = font_mirror[(base + k * GLYPH_ROWS) % FONT_DEPTH];
              end
              // Nibble bit k of pixel px is bit (7 - px) of plane k.
              for (int px = 0; px < 8; px++) begin
                for (int k = 0; k < PLANES; k++) begin
                  want.pixels[28 - 4 * px + k] = plane[k][7 - px];
                end
              end
            end
            want.row  = ROW_W'(row);
            want.last = (row == GLYPH_ROWS - 1);
            rows_due.push_back(want);
          end
        end
      end
      if (pix.valid && pix.ready) begin
        if (rows_due.size() == 0) begin
          report($sformatf("unexpected row: pixels %h index %0d last %b",
                           pix.row_pixels, pix.row_index, pix.last_row));
        end else begin
          want = rows_due.pop_front();
          if (pix.row_pixels !== want.pixels || pix.row_index !== want.row ||
              pix.last_row !== want.last) begin
            report($sformatf("got pixels %h index %0d last %b, expected %h index %0d last %b",
                             pix.row_pixels, pix.row_index, pix.last_row,
                             want.pixels, want.row, want.last));
          end
          rows_seen++;
        end
      end
    end
    backlog <= rows_due.size();
  end

endmodule
`default_nettype wire

// ----- test/planar_font_glyph_renderer_test.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// planar_font_glyph_renderer_test: top of the glyph renderer testbench
// Drives load and render commands with random gaps, stalls the pixel row
// channel in random bursts and once for a long stretch, and leaves all
// prediction and comparison to pfgr_render_checker.
// ----------------------------------------------------------------------------
module planar_font_glyph_renderer_test;
  import pfgr_pkg::*;
  import pfgr_check_pkg::*;

  localparam int ROWS         = GLYPH_ROWS_DEF;
  localparam int GLYPH_BYTES  = PLANES * ROWS;
  localparam int RAND_ITEMS   = 100;
  localparam int RAND_RENDERS = 16;
  localparam int PLAN_GLYPHS  = 2;
  localparam int HOLD_CYCLES  = 400;
  // Long enough for one more mapped character to come out, with margin.
  localparam int DRAIN_CYCLES = 6 * ROWS + 8;
  localparam int CYCLE_LIMIT  = 200000;

  // Ways of filling the four planes of a glyph while it is loaded.
  typedef enum int {
    FILL_ONES,
    FILL_ZEROS,
    FILL_ONE_PLANE,
    FILL_RANDOM
  } fill_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #2 clk = ~clk;

  pfgr_in_if  cmd ();
  pfgr_out_if pix ();

  planar_font_glyph_renderer u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .pix (pix)
  );

  int fail_count;
  int rows_pending;
  int rows_checked;

  pfgr_render_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .pix          (pix),
    .fail_count   (fail_count),
    .rows_pending (rows_pending),
    .rows_checked (rows_checked)
  );

  // Stimulus bookkeeping. A glyph may be rendered only once all of its plane
  // bytes have been loaded, since the font store powers up undefined.
  bit glyph_loaded [GLYPH_COUNT];
  int glyphs_loaded = 0;
  int loads_sent    = 0;
  int renders_sent  = 0;
  int unmapped_sent = 0;

  // Idle control. The sender's gap chance is picked per episode; calm turns
  // off all idling for the final part of the run, and hold_off is the one
  // long stall of the pixel row channel.
  int idle_levels [3] = '{0, 15, 40};
  int send_idle_pct   = 0;
  bit calm            = 1'b0;
  bit hold_off        = 1'b0;

  // Offers one command and returns after its transfer. An optional gap with
  // valid low comes first. The valid level is only ever changed once per
  // time step, so back-to-back commands keep valid high.
  task automatic send_item(input op_t op, input logic [ADDR_W-1:0] addr,
                           input logic [BYTE_W-1:0] data,
                           input logic [CODE_W-1:0] code);
    int gap;
    if (!calm && $urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 16);
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid     <= 1'b1;
    cmd.op        <= op;
    cmd.font_addr <= addr;
    cmd.font_byte <= data;
    cmd.char_code <= code;
    do @(posedge clk); while (!cmd.ready);
    if (op == OP_LOAD) begin
      loads_sent++;
    end else begin
      renders_sent++;
      if (glyph_number(code) < 0) begin
        unmapped_sent++;
      end
    end
  endtask

  // Pixel row sink. It alternates between phases of different stall density
  // (including phases with no stalls at all), stalls in bursts, and is held
  // off entirely while hold_off is set.
  initial begin : row_sink
    int stall_left;
    int stall_pct;
    int phase_left;
    int stall_levels [3];
    stall_levels = '{0, 10, 35};
    stall_left   = 0;
    stall_pct    = 0;
    phase_left   = 0;
    pix.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (phase_left == 0) begin
        phase_left = 128;
        stall_pct  = stall_levels[$urandom_range(0, 2)];
      end
      phase_left--;
      if (hold_off) begin
        pix.ready <= 1'b0;
      end else if (stall_left > 0 && !calm) begin
        stall_left--;
        pix.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 16) - 1;
        pix.ready <= 1'b0;
      end else begin
        pix.ready <= 1'b1;
      end
    end
  end

  // Long back-pressure stretch. It starts once the random part is under way,
  // so the sender keeps offering commands; the block fills with the rows of
  // the current character and has to drop its command ready.
  initial begin : long_hold
    wait (renders_sent >= 20);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timed out after %0d cycles with %0d rows still due", cycles, rows_pending);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [CODE_W-1:0] probes [14];
    logic [CODE_W-1:0] code;
    logic [BYTE_W-1:0] data;
    int                glyph_plan [PLAN_GLYPHS];
    int                plan_pos;
    int                items;
    int                renders_rand;
    int                roll;
    int                g;
    int                step;
    int                first;
    int                offset;
    int                lit_plane;
    int                pick;
    fill_t             fill;

    cmd.valid     <= 1'b0;
    cmd.op        <= OP_LOAD;
    cmd.font_addr <= '0;
    cmd.font_byte <= '0;
    cmd.char_code <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Loads at the lowest and highest store address and one
    // with the top address bit set, then renders of codes without a glyph:
    // the code extremes, both neighbors of each mapped range and one of each mark.
    // These never touch the store, so the store may still be unwritten.
    send_idle_pct = 20;
    send_item(OP_LOAD, '0, 8'hFF, 8'h00);
    send_item(OP_LOAD, {ADDR_W{1'b1}}, 8'h00, 8'hFF);
    send_item(OP_LOAD, ADDR_W'(1024), 8'hA5, 8'h5A);
    probes = '{8'h00, 8'hFF, 8'h2F, 8'h3A, 8'h40, 8'h5B, 8'h60,
               8'h7B, 8'h80, 8'h20, 8'h23, 8'h25, 8'h3E, 8'h5E};
    foreach (probes[i]) begin
      send_item(OP_RENDER, ADDR_W'($urandom), BYTE_W'($urandom), probes[i]);
    end

    // Random part. Episodes either load a whole glyph (four planes with a
    // random fill pattern, in a scrambled byte order), write a stray byte
    // anywhere in the store, render a code with no glyph, or render a
    // character whose glyph is fully loaded, in either letter case. At most two
    // glyphs are loaded: the last letter, and either the lowest digit or
    // one of the punctuation marks.
    glyph_plan = '{GLYPH_COUNT - 1, 0};
    if ($urandom_range(0, 1) != 0) begin
      glyph_plan[1] = int'(GLYPH_EXCL) + int'($urandom_range(0, 4));
    end
    plan_pos     = 0;
    items        = 0;
    renders_rand = 0;
    while (items < RAND_ITEMS || renders_rand < RAND_RENDERS) begin
      // The tail of the run goes without any idling on either side.
      if (renders_rand >= RAND_RENDERS - 8) begin
        calm <= 1'b1;
      end
      send_idle_pct = idle_levels[$urandom_range(0, 2)];
      roll = $urandom_range(0, 99);
      if (plan_pos < PLAN_GLYPHS && roll < 20) begin
        g = glyph_plan[plan_pos];
        plan_pos++;
        // An odd step that is no multiple of three visits all 48 bytes.
        step = 2 * $urandom_range(0, 23) + 1;
        if (step % 3 == 0) begin
          step += 2;
        end
        first     = $urandom_range(0, GLYPH_BYTES - 1);
        lit_plane = $urandom_range(0, PLANES - 1);
        pick      = $urandom_range(0, 5);
        fill      = (pick > 3) ? FILL_RANDOM : fill_t'(pick);
        for (int i = 0; i < GLYPH_BYTES; i++) begin
          offset = (first + i * step) % GLYPH_BYTES;
          case (fill)
            FILL_ONES:      data = 8'hFF;
            FILL_ZEROS:     data = 8'h00;
            FILL_ONE_PLANE: data = (offset / ROWS == lit_plane) ? BYTE_W'($urandom) : 8'h00;
            default:        data = BYTE_W'($urandom);
          endcase
          send_item(OP_LOAD, ADDR_W'(g * GLYPH_BYTES + offset), data, CODE_W'($urandom));
        end
        glyph_loaded[g] = 1'b1;
        glyphs_loaded++;
        items += GLYPH_BYTES;
      end else if (roll < 25) begin
        // Stray byte: may land inside a loaded glyph and change it.
        send_item(OP_LOAD, ADDR_W'($urandom_range(0, FONT_DEPTH_DEF - 1)),
                  BYTE_W'($urandom), CODE_W'($urandom));
        items++;
      end else if (roll < 45 || glyphs_loaded == 0) begin
        do code = CODE_W'($urandom); while (glyph_number(code) >= 0);
        send_item(OP_RENDER, ADDR_W'($urandom), BYTE_W'($urandom), code);
        items++;
        renders_rand++;
      end else begin
        do g = $urandom_range(0, GLYPH_COUNT - 1); while (!glyph_loaded[g]);
        if (g < 10) begin
          code = CODE_W'(int'(CH_ZERO) + g);
        end else if (g >= int'(GLYPH_ALPHA)) begin
          code = CODE_W'(int'($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) +
                         g - int'(GLYPH_ALPHA));
        end else begin
          case (g)
            int'(GLYPH_EXCL):   code = CH_EXCL;
            int'(GLYPH_QUEST):  code = CH_QUEST;
            int'(GLYPH_DOT):    code = CH_DOT;
            int'(GLYPH_DOLLAR): code = CH_DOLLAR;
            default:            code = CH_UNDER;
          endcase
        end
        send_item(OP_RENDER, ADDR_W'($urandom), BYTE_W'($urandom), code);
        items++;
        renders_rand++;
      end
    end
    cmd.valid <= 1'b0;

    // Drain: wait until every predicted row has come out, then give the
    // block time to show any row that nobody asked for.
    do @(posedge clk); while (rows_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d font byte loads, %0d glyphs fully loaded and %0d renders",
             loads_sent, glyphs_loaded, renders_sent);
    $display("(%0d of them codes without a glyph); %0d pixel rows compared, %0d failures",
             unmapped_sent, rows_checked, fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
